// ===== rtl/core/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, constants and helper functions of the single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int TIMER_BITS = 10;
	localparam int CFG_BITS   = 10;
	localparam int NUM_CFG    = 8;
	localparam int ADDR_BITS  = 5;
	localparam int DATA_BITS  = 32;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX      = '1;
	localparam logic [TIMER_BITS-1:0] POLL_TICKS     = TIMER_BITS'(10);
	localparam logic [TIMER_BITS-1:0] RECOVERY_TICKS = TIMER_BITS'(10);
	localparam logic [4:0]            POLL_LIMIT     = 5'd17;
	localparam logic [7:0]            CRC_POLY_X     = 8'h18;
	localparam logic [7:0]            CRC_TOP        = 8'h80;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_RESET = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	typedef enum logic [2:0] {
		CFG_RST_LOW,
		CFG_PRES_WAIT,
		CFG_RST_TAIL,
		CFG_RD_LOW,
		CFG_RD_SAMPLE,
		CFG_RD_TAIL,
		CFG_WR_LOW,
		CFG_WR_SLOT
	} cfg_idx_t;

	localparam logic [CFG_BITS-1:0] RST_LOW_RESET   = 10'd480;
	localparam logic [CFG_BITS-1:0] PRES_WAIT_RESET = 10'd80;
	localparam logic [CFG_BITS-1:0] RST_TAIL_RESET  = 10'd400;
	localparam logic [CFG_BITS-1:0] RD_LOW_RESET    = 10'd3;
	localparam logic [CFG_BITS-1:0] RD_SAMPLE_RESET = 10'd5;
	localparam logic [CFG_BITS-1:0] RD_TAIL_RESET   = 10'd55;
	localparam logic [CFG_BITS-1:0] WR_LOW_RESET    = 10'd5;
	localparam logic [CFG_BITS-1:0] WR_SLOT_RESET   = 10'd60;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_POLL,
		PH_RST_TAIL,
		PH_WR_LOW,
		PH_WR_SLOT,
		PH_WR_REC,
		PH_RD_LOW,
		PH_RD_WAIT,
		PH_RD_TAIL
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       bus_level;
	} tick_word_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       device_present;
		logic [7:0] read_data;
		logic [7:0] crc_value;
	} result_word_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] rst_low;
		logic [CFG_BITS-1:0] pres_wait;
		logic [CFG_BITS-1:0] rst_tail;
		logic [CFG_BITS-1:0] rd_low;
		logic [CFG_BITS-1:0] rd_sample;
		logic [CFG_BITS-1:0] rd_tail;
		logic [CFG_BITS-1:0] wr_low;
		logic [CFG_BITS-1:0] wr_slot;
	} cfg_t;

	function automatic logic [TIMER_BITS-1:0] load_ticks(input logic [CFG_BITS-1:0] v);
		logic [TIMER_BITS-1:0] t;
		if (32'(v) > 32'(TIMER_MAX)) begin
			t = TIMER_MAX;
		end else begin
			t = TIMER_BITS'(v);
		end
		if (t == '0) begin
			t = TIMER_BITS'(1);
		end
		return t;
	endfunction

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] crc;
		crc = crc_in;
		for (int i = 0; i < 8; i++) begin
			if (crc[0] ^ b[i]) begin
				crc = ((crc ^ CRC_POLY_X) >> 1) | CRC_TOP;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

// ===== rtl/core/owbm_regs.sv =====
// ----------------------------------------------------------------------------
// owbm_regs
// APB-style register file holding the eight slot timing registers.
// ----------------------------------------------------------------------------
module owbm_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [owbm_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [owbm_pkg::DATA_BITS-1:0]  pwdata,
	output logic [owbm_pkg::DATA_BITS-1:0]  prdata,
	output logic                            pready,
	output owbm_pkg::cfg_t                  cfg
);
	import owbm_pkg::*;

	cfg_t                cfg_q;
	cfg_idx_t            idx;
	logic                wr_en;
	logic [CFG_BITS-1:0] wval;
	logic [CFG_BITS-1:0] rval;

	assign pready = 1'b1;
	assign idx    = cfg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign wval   = pwdata[CFG_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rst_low   <= RST_LOW_RESET;
			cfg_q.pres_wait <= PRES_WAIT_RESET;
			cfg_q.rst_tail  <= RST_TAIL_RESET;
			cfg_q.rd_low    <= RD_LOW_RESET;
			cfg_q.rd_sample <= RD_SAMPLE_RESET;
			cfg_q.rd_tail   <= RD_TAIL_RESET;
			cfg_q.wr_low    <= WR_LOW_RESET;
			cfg_q.wr_slot   <= WR_SLOT_RESET;
		end else if (wr_en) begin
			case (idx)
				CFG_RST_LOW:   cfg_q.rst_low   <= wval;
				CFG_PRES_WAIT: cfg_q.pres_wait <= wval;
				CFG_RST_TAIL:  cfg_q.rst_tail  <= wval;
				CFG_RD_LOW:    cfg_q.rd_low    <= wval;
				CFG_RD_SAMPLE: cfg_q.rd_sample <= wval;
				CFG_RD_TAIL:   cfg_q.rd_tail   <= wval;
				CFG_WR_LOW:    cfg_q.wr_low    <= wval;
				CFG_WR_SLOT:   cfg_q.wr_slot   <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			CFG_RST_LOW:   rval = cfg_q.rst_low;
			CFG_PRES_WAIT: rval = cfg_q.pres_wait;
			CFG_RST_TAIL:  rval = cfg_q.rst_tail;
			CFG_RD_LOW:    rval = cfg_q.rd_low;
			CFG_RD_SAMPLE: rval = cfg_q.rd_sample;
			CFG_RD_TAIL:   rval = cfg_q.rd_tail;
			CFG_WR_LOW:    rval = cfg_q.wr_low;
			CFG_WR_SLOT:   rval = cfg_q.wr_slot;
			default:       rval = '0;
		endcase
	end

	assign prdata = DATA_BITS'(rval);
	assign cfg    = cfg_q;

endmodule

// ===== rtl/core/owbm_core.sv =====
// ----------------------------------------------------------------------------
// owbm_core
// Bus timing sequencer: advances the reset, write and read slots by one tick
// per word and forms the result word for that tick.
// ----------------------------------------------------------------------------
module owbm_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  owbm_pkg::tick_word_t   tick,
	input  owbm_pkg::cfg_t         cfg,
	output owbm_pkg::result_word_t result
);
	import owbm_pkg::*;

	phase_t                phase_q,  phase_n;
	logic [TIMER_BITS-1:0] timer_q,  timer_n;
	logic [2:0]            bit_q,    bit_n;
	logic [7:0]            shift_q,  shift_n;
	logic [4:0]            poll_q,   poll_n;
	logic [7:0]            crc_q,    crc_n;
	logic                  pres_q,   pres_n;
	logic [7:0]            last_q,   last_n;
	logic                  drive;
	logic                  done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			poll_q  <= '0;
			crc_q   <= '0;
			pres_q  <= 1'b0;
			last_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			timer_q <= timer_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			poll_q  <= poll_n;
			crc_q   <= crc_n;
			pres_q  <= pres_n;
			last_q  <= last_n;
		end
	end

	always_comb begin
		phase_n = phase_q;
		timer_n = timer_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		poll_n  = poll_q;
		crc_n   = crc_q;
		pres_n  = pres_q;
		last_n  = last_q;
		drive   = 1'b0;
		done    = 1'b0;

		if (phase_q == PH_IDLE) begin
			case (tick.func)
				FUNC_RESET: begin
					poll_n  = '0;
					crc_n   = '0;
					pres_n  = 1'b0;
					phase_n = PH_RST_LOW;
					timer_n = load_ticks(cfg.rst_low);
				end
				FUNC_WRITE: begin
					shift_n = tick.data_byte;
					bit_n   = '0;
					phase_n = PH_WR_LOW;
					timer_n = load_ticks(cfg.wr_low);
				end
				FUNC_READ: begin
					shift_n = '0;
					bit_n   = '0;
					phase_n = PH_RD_LOW;
					timer_n = load_ticks(cfg.rd_low);
				end
				default: ;
			endcase
		end

		if (phase_n != PH_IDLE) begin
			if (phase_n == PH_RST_LOW || phase_n == PH_WR_LOW || phase_n == PH_RD_LOW ||
			    (phase_n == PH_WR_SLOT && !shift_n[0])) begin
				drive = 1'b1;
			end
			if (timer_n != '0) begin
				timer_n = timer_n - TIMER_BITS'(1);
			end
			if (timer_n == '0) begin
				case (phase_n)
					PH_RST_LOW: begin
						phase_n = PH_RST_WAIT;
						timer_n = load_ticks(cfg.pres_wait);
					end
					PH_RST_WAIT: begin
						if (!tick.bus_level) begin
							pres_n  = 1'b1;
							phase_n = PH_RST_TAIL;
							timer_n = load_ticks(cfg.rst_tail);
						end else begin
							phase_n = PH_RST_POLL;
							timer_n = POLL_TICKS;
						end
					end
					PH_RST_POLL: begin
						poll_n = poll_n + 5'd1;
						if (!tick.bus_level || poll_n >= POLL_LIMIT) begin
							pres_n  = !tick.bus_level;
							phase_n = PH_RST_TAIL;
							timer_n = load_ticks(cfg.rst_tail);
						end else begin
							phase_n = PH_RST_POLL;
							timer_n = POLL_TICKS;
						end
					end
					PH_RST_TAIL: begin
						phase_n = PH_IDLE;
						done    = 1'b1;
					end
					PH_WR_LOW: begin
						phase_n = PH_WR_SLOT;
						timer_n = load_ticks(cfg.wr_slot);
					end
					PH_WR_SLOT: begin
						phase_n = PH_WR_REC;
						timer_n = RECOVERY_TICKS;
					end
					PH_WR_REC: begin
						if (bit_n == 3'd7) begin
							phase_n = PH_IDLE;
							done    = 1'b1;
							bit_n   = '0;
						end else begin
							bit_n   = bit_n + 3'd1;
							shift_n = shift_n >> 1;
							phase_n = PH_WR_LOW;
							timer_n = load_ticks(cfg.wr_low);
						end
					end
					PH_RD_LOW: begin
						phase_n = PH_RD_WAIT;
						timer_n = load_ticks(cfg.rd_sample);
					end
					PH_RD_WAIT: begin
						shift_n = {tick.bus_level, shift_n[7:1]};
						phase_n = PH_RD_TAIL;
						timer_n = load_ticks(cfg.rd_tail);
					end
					PH_RD_TAIL: begin
						if (bit_n == 3'd7) begin
							last_n  = shift_n;
							crc_n   = crc8_byte(crc_n, shift_n);
							phase_n = PH_IDLE;
							done    = 1'b1;
							bit_n   = '0;
						end else begin
							bit_n   = bit_n + 3'd1;
							phase_n = PH_RD_LOW;
							timer_n = load_ticks(cfg.rd_low);
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end

		result.drive_low      = drive;
		result.busy_res       = (phase_n != PH_IDLE);
		result.done_res       = done;
		result.device_present = pres_n;
		result.read_data      = last_n;
		result.crc_value      = crc_n;
	end

endmodule

// ===== rtl/core/one_wire_bus_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Single-wire bus master with slot timing registers and a CRC-8 over read bytes.
// ----------------------------------------------------------------------------
// Each tick word is one microsecond of bus time and yields exactly one result
// word. A word is taken into an input register, passes combinationally through
// the slot sequencer and lands in a result register, so one word is accepted
// every cycle while the tick stall is low; the tick stall rises only when both
// registers are full and the result side is stalled.
module one_wire_bus_master (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick_valid,
	output logic                            tick_stall,
	input  owbm_pkg::tick_word_t            tick_word,
	output logic                            result_valid,
	input  logic                            result_stall,
	output owbm_pkg::result_word_t          result_word,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [owbm_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [owbm_pkg::DATA_BITS-1:0]  pwdata,
	output logic [owbm_pkg::DATA_BITS-1:0]  prdata,
	output logic                            pready
);
	import owbm_pkg::*;

	logic         valid_s1;
	tick_word_t   word_s1;
	logic         res_valid_q;
	result_word_t res_q;
	result_word_t res_d;
	cfg_t         cfg;
	logic         advance;
	logic         take;

	assign advance    = valid_s1 && !(res_valid_q && result_stall);
	assign tick_stall = valid_s1 && res_valid_q && result_stall;
	assign take       = tick_valid && !tick_stall;

	owbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	owbm_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.tick    (word_s1),
		.cfg     (cfg),
		.result  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= tick_word;
		end
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result_word  = res_q;

endmodule

// ===== rtl/core/owbm_checker.sv =====
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks of the single-wire bus master, bound to the top level.
// ----------------------------------------------------------------------------
module owbm_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_valid,
	input  logic                   tick_stall,
	input  owbm_pkg::tick_word_t   tick_word,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  owbm_pkg::result_word_t result_word
);
	import owbm_pkg::*;

	a_tick_held: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_stall |=> tick_valid && $stable(tick_word))
		else $error("stalled tick word changed");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_word))
		else $error("stalled result word changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> result_valid && result_stall)
		else $error("tick stall without a stalled result word");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.done_res |-> !result_word.busy_res)
		else $error("completion word still busy");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.drive_low |-> result_word.busy_res)
		else $error("bus driven low while idle");

endmodule

bind one_wire_bus_master owbm_checker u_checker (.*);
